>>> hdl/gasp_pkg.sv
// ----------------------------------------------------------------------------
// gasp_pkg: shared codes for the grid path search block
// Command codes, register indexes, neighbor order and sequencer states.
// ----------------------------------------------------------------------------
package gasp_pkg;

  // command codes carried in tuser
  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_SEARCH = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  // configuration register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // neighbor order: up, left, right, down
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_RIGHT = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

  localparam int unsigned LENGTH_LIMIT = 1023;

  typedef enum logic [14:0] {
    ST_IDLE    = 15'b000000000000001,
    ST_RDWAIT  = 15'b000000000000010,
    ST_GOAL    = 15'b000000000000100,
    ST_NB      = 15'b000000000001000,
    ST_MAPW    = 15'b000000000010000,
    ST_SCAN    = 15'b000000000100000,
    ST_NEXTDIR = 15'b000000001000000,
    ST_CLOSE   = 15'b000000010000000,
    ST_MINST   = 15'b000000100000000,
    ST_MIN     = 15'b000001000000000,
    ST_MINEND  = 15'b000010000000000,
    ST_LOADCUR = 15'b000100000000000,
    ST_PATH    = 15'b001000000000000,
    ST_PWAIT   = 15'b010000000000000,
    ST_DONE    = 15'b100000000000000
  } state_e;

endpackage

>>> hdl/gasp_ram.sv
// ----------------------------------------------------------------------------
// gasp_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module gasp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/grid_astar_path_search.sv
// ----------------------------------------------------------------------------
// grid_astar_path_search: A* search on a 4-connected grid
// Loads a passability map, searches start to goal, reads back path steps.
// ----------------------------------------------------------------------------
// A cell load passes through the done state, and a path step read through the
// read wait and done states, before its result beat is registered. A search
// is run by a sequencer around one node table RAM with a single read port:
// each expansion walks the table once per passable neighbor to look it up
// (one entry a cycle) and once more to pick the lowest f, and the found path
// is stored node by node through the path and parent wait states. The block
// takes no new beat while a command is in work; one finished result may wait
// on the output while the next command runs. Node slots are tracked by a fill
// count, so no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module grid_astar_path_search #(
  parameter int MAX_WIDTH     = 64,
  parameter int MAX_HEIGHT    = 64,
  parameter int NODE_CAPACITY = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [6:0]  cfg_data_i,
  // command stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: cell_x[5:0], cell_y[11:6], cell_passable[12], from_x[18:13],
  //        from_y[24:19], to_x[30:25], to_y[36:31], step_index[45:37], pad
  input  logic [47:0] s_axis_tdata,
  // tuser: cmd[1:0]
  input  logic [1:0]  s_axis_tuser,
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: found[0], path_length[10:1], step_x[16:11], step_y[22:17], pad
  output logic [23:0] m_axis_tdata
);
  import gasp_pkg::*;

  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int MD  = MAX_WIDTH * MAX_HEIGHT;
  localparam int MAW = $clog2(MD);
  localparam int NIW = $clog2(NODE_CAPACITY);
  localparam int CNW = $clog2(NODE_CAPACITY + 1);
  localparam int CW  = $clog2(NODE_CAPACITY + 1);
  localparam int EW  = $clog2(MAX_WIDTH + MAX_HEIGHT);
  localparam int FW  = ((CW > EW) ? CW : EW) + 1;

  typedef struct packed {
    logic [XW-1:0]  x;
    logic [YW-1:0]  y;
    logic [CW-1:0]  cost;
    logic [EW-1:0]  est;
    logic [NIW-1:0] par;
    logic           open;
  } node_t;

  localparam int NODEW = $bits(node_t);

  // input fields
  logic [5:0] cell_x, cell_y, from_x, from_y, to_x, to_y;
  logic       cell_passable;
  logic [8:0] step_index;
  logic [1:0] cmd;

  assign cell_x        = s_axis_tdata[5:0];
  assign cell_y        = s_axis_tdata[11:6];
  assign cell_passable = s_axis_tdata[12];
  assign from_x        = s_axis_tdata[18:13];
  assign from_y        = s_axis_tdata[24:19];
  assign to_x          = s_axis_tdata[30:25];
  assign to_y          = s_axis_tdata[36:31];
  assign step_index    = s_axis_tdata[45:37];
  assign cmd           = s_axis_tuser;

  // registers
  state_e         state_q, state_d;
  logic [6:0]     cfg_w_q, cfg_h_q;
  logic [WW-1:0]  w_q, w_d;
  logic [HW-1:0]  h_q, h_d;
  logic [CNW-1:0] cap_q, cap_d;
  logic [CNW-1:0] cnt_q, cnt_d;
  logic [XW-1:0]  tx_q, tx_d;
  logic [YW-1:0]  ty_q, ty_d;
  node_t          cur_q, cur_d;
  logic [NIW-1:0] cur_idx_q, cur_idx_d;
  logic [1:0]     dir_q, dir_d;
  logic [XW-1:0]  nx_q, nx_d;
  logic [YW-1:0]  ny_q, ny_d;
  logic [EW-1:0]  nest_q, nest_d;
  logic [NIW-1:0] i_q, i_d;
  logic           have_q, have_d;
  logic [FW-1:0]  bestf_q, bestf_d;
  logic [NIW-1:0] best_q, best_d;
  logic [CNW-1:0] len_q, len_d;
  logic           found_q, found_d;
  logic [9:0]     last_len_q, last_len_d;
  logic [5:0]     sx_q, sx_d, sy_q, sy_d;
  logic           m_valid_q, m_valid_d;
  logic [23:0]    m_data_q, m_data_d;

  // memory ports
  logic              map_we, map_rd;
  logic [MAW-1:0]    map_waddr, map_raddr;
  logic              node_we;
  logic [NIW-1:0]    node_waddr, node_raddr;
  node_t             node_wdata, node_rd;
  logic [NODEW-1:0]  node_rdata;
  logic              path_we;
  logic [NIW-1:0]    path_waddr, path_raddr;
  logic [XW+YW-1:0]  path_wdata, path_rdata;

  assign node_rd = node_t'(node_rdata);

  gasp_ram #(.WIDTH(1), .DEPTH(MD)) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (cell_passable),
    .raddr_i (map_raddr),
    .rdata_o (map_rd)
  );

  gasp_ram #(.WIDTH(NODEW), .DEPTH(NODE_CAPACITY)) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (node_waddr),
    .wdata_i (node_wdata),
    .raddr_i (node_raddr),
    .rdata_o (node_rdata)
  );

  gasp_ram #(.WIDTH(XW + YW), .DEPTH(NODE_CAPACITY)) u_path_ram (
    .clk_i   (clk_i),
    .we_i    (path_we),
    .waddr_i (path_waddr),
    .wdata_i (path_wdata),
    .raddr_i (path_raddr),
    .rdata_o (path_rdata)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= 7'd64;
      cfg_h_q <= 7'd64;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_WIDTH) begin
        cfg_w_q <= cfg_data_i;
      end else begin
        cfg_h_q <= cfg_data_i;
      end
    end
  end

  // effective grid size, saturated to storage
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  always_comb begin
    w_eff = ({25'd0, cfg_w_q} > 32'(MAX_WIDTH))  ? WW'(MAX_WIDTH)  : WW'(cfg_w_q);
    h_eff = ({25'd0, cfg_h_q} > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(cfg_h_q);
  end

  logic s_fire;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // neighbor candidate from the current node
  logic [XW:0]   nxe;
  logic [YW:0]   nye;
  logic          nb_oob;
  logic [XW-1:0] nb_x;
  logic [YW-1:0] nb_y;
  logic [EW-1:0] nb_est;
  always_comb begin
    nxe    = {1'b0, cur_q.x};
    nye    = {1'b0, cur_q.y};
    nb_oob = 1'b0;
    case (dir_q)
      DIR_UP: begin
        nb_oob = (cur_q.y == '0);
        nye    = nye - 1'b1;
      end
      DIR_LEFT: begin
        nb_oob = (cur_q.x == '0);
        nxe    = nxe - 1'b1;
      end
      DIR_RIGHT: begin
        nxe    = nxe + 1'b1;
        nb_oob = (32'(nxe) >= 32'(w_q));
      end
      DIR_DOWN: begin
        nye    = nye + 1'b1;
        nb_oob = (32'(nye) >= 32'(h_q));
      end
      default: nb_oob = 1'b1;
    endcase
    nb_x   = XW'(nxe);
    nb_y   = YW'(nye);
    nb_est = EW'(((nb_x > tx_q) ? 32'(nb_x - tx_q) : 32'(tx_q - nb_x)) +
                 ((nb_y > ty_q) ? 32'(nb_y - ty_q) : 32'(ty_q - nb_y)));
  end

  // start node estimate and endpoint checks
  logic          ep_ok;
  logic [EW-1:0] st_est;
  logic [XW-1:0] fx_t, tx_t;
  logic [YW-1:0] fy_t, ty_t;
  always_comb begin
    ep_ok = (32'(from_x) < 32'(w_eff)) && (32'(from_y) < 32'(h_eff)) &&
            (32'(to_x) < 32'(w_eff)) && (32'(to_y) < 32'(h_eff));
    fx_t  = XW'(from_x);
    fy_t  = YW'(from_y);
    tx_t  = XW'(to_x);
    ty_t  = YW'(to_y);
    st_est = EW'(((fx_t > tx_t) ? 32'(fx_t - tx_t) : 32'(tx_t - fx_t)) +
                 ((fy_t > ty_t) ? 32'(fy_t - ty_t) : 32'(ty_t - fy_t)));
  end

  logic [CW:0]   cost_next;
  logic [FW-1:0] rd_f;
  logic          last_entry;
  logic [CNW:0]  new_len;
  assign cost_next  = {1'b0, cur_q.cost} + 1'b1;
  assign rd_f       = FW'(node_rd.cost) + FW'(node_rd.est);
  assign last_entry = ((CNW'(i_q) + 1'b1) == cnt_q);
  assign new_len    = {1'b0, len_q} + 1'b1;

  // sequencer
  always_comb begin
    state_d    = state_q;
    w_d        = w_q;
    h_d        = h_q;
    cap_d      = cap_q;
    cnt_d      = cnt_q;
    tx_d       = tx_q;
    ty_d       = ty_q;
    cur_d      = cur_q;
    cur_idx_d  = cur_idx_q;
    dir_d      = dir_q;
    nx_d       = nx_q;
    ny_d       = ny_q;
    nest_d     = nest_q;
    i_d        = i_q;
    have_d     = have_q;
    bestf_d    = bestf_q;
    best_d     = best_q;
    len_d      = len_q;
    found_d    = found_q;
    last_len_d = last_len_q;
    sx_d       = sx_q;
    sy_d       = sy_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    m_data_d   = m_data_q;

    map_we     = 1'b0;
    map_waddr  = MAW'(cell_y) * MAW'(MAX_WIDTH) + MAW'(cell_x);
    map_raddr  = MAW'(nb_y) * MAW'(MAX_WIDTH) + MAW'(nb_x);
    node_we    = 1'b0;
    node_waddr = '0;
    node_wdata = cur_q;
    node_raddr = NIW'(i_q + 1'b1);
    path_we    = 1'b0;
    path_waddr = NIW'(len_q);
    path_wdata = {cur_q.y, cur_q.x};
    path_raddr = NIW'(step_index);

    case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          sx_d    = '0;
          sy_d    = '0;
          state_d = ST_DONE;
          case (cmd)
            CMD_LOAD: begin
              map_we = (32'(cell_x) < 32'(MAX_WIDTH)) && (32'(cell_y) < 32'(MAX_HEIGHT));
            end
            CMD_SEARCH: begin
              found_d    = 1'b0;
              last_len_d = '0;
              w_d        = w_eff;
              h_d        = h_eff;
              tx_d       = tx_t;
              ty_d       = ty_t;
              cap_d      = (32'(w_eff) * 32'(h_eff) > 32'(NODE_CAPACITY)) ?
                           CNW'(NODE_CAPACITY) : CNW'(32'(w_eff) * 32'(h_eff));
              if (ep_ok) begin
                cur_d.x    = fx_t;
                cur_d.y    = fy_t;
                cur_d.cost = '0;
                cur_d.est  = st_est;
                cur_d.par  = '0;
                cur_d.open = 1'b1;
                node_we    = 1'b1;
                node_waddr = '0;
                node_wdata = cur_d;
                cur_idx_d  = '0;
                cnt_d      = CNW'(1);
                state_d    = ST_GOAL;
              end
            end
            CMD_READ: begin
              if ((32'(step_index) < 32'(last_len_q)) &&
                  (32'(step_index) < 32'(NODE_CAPACITY))) begin
                state_d = ST_RDWAIT;
              end
            end
            default: state_d = ST_DONE;
          endcase
        end
      end

      ST_RDWAIT: begin
        sx_d    = 6'(path_rdata[XW-1:0]);
        sy_d    = 6'(path_rdata[XW+YW-1:XW]);
        state_d = ST_DONE;
      end

      // goal test, then walk the four neighbors
      ST_GOAL: begin
        if (cur_q.x == tx_q && cur_q.y == ty_q) begin
          len_d   = '0;
          state_d = ST_PATH;
        end else begin
          dir_d   = DIR_UP;
          state_d = ST_NB;
        end
      end

      ST_NB: begin
        nx_d   = nb_x;
        ny_d   = nb_y;
        nest_d = nb_est;
        state_d = nb_oob ? ST_NEXTDIR : ST_MAPW;
      end

      ST_MAPW: begin
        node_raddr = '0;
        i_d        = '0;
        state_d    = map_rd ? ST_SCAN : ST_NEXTDIR;
      end

      // look the neighbor up in the table, one entry a cycle
      ST_SCAN: begin
        if (node_rd.x == nx_q && node_rd.y == ny_q) begin
          if ({1'b0, node_rd.cost} > cost_next) begin
            node_we        = 1'b1;
            node_waddr     = i_q;
            node_wdata     = node_rd;
            node_wdata.par = cur_idx_q;
          end
          state_d = ST_NEXTDIR;
        end else if (last_entry) begin
          if (cnt_q < cap_q) begin
            node_we         = 1'b1;
            node_waddr      = NIW'(cnt_q);
            node_wdata.x    = nx_q;
            node_wdata.y    = ny_q;
            node_wdata.cost = CW'(cost_next);
            node_wdata.est  = nest_q;
            node_wdata.par  = cur_idx_q;
            node_wdata.open = 1'b1;
            cnt_d           = cnt_q + 1'b1;
          end
          state_d = ST_NEXTDIR;
        end else begin
          i_d = i_q + 1'b1;
        end
      end

      ST_NEXTDIR: begin
        if (dir_q == DIR_DOWN) begin
          state_d = ST_CLOSE;
        end else begin
          dir_d   = dir_q + 1'b1;
          state_d = ST_NB;
        end
      end

      ST_CLOSE: begin
        node_we         = 1'b1;
        node_waddr      = cur_idx_q;
        node_wdata.open = 1'b0;
        state_d         = ST_MINST;
      end

      ST_MINST: begin
        node_raddr = '0;
        i_d        = '0;
        have_d     = 1'b0;
        state_d    = ST_MIN;
      end

      // first lowest f among open nodes
      ST_MIN: begin
        if (node_rd.open && (!have_q || rd_f < bestf_q)) begin
          have_d  = 1'b1;
          bestf_d = rd_f;
          best_d  = i_q;
        end
        if (last_entry) begin
          state_d = ST_MINEND;
        end else begin
          i_d = i_q + 1'b1;
        end
      end

      ST_MINEND: begin
        node_raddr = best_q;
        state_d    = have_q ? ST_LOADCUR : ST_DONE;
      end

      ST_LOADCUR: begin
        cur_d     = node_rd;
        cur_idx_d = best_q;
        state_d   = ST_GOAL;
      end

      // store the path goal first, following parents
      ST_PATH: begin
        path_we    = 1'b1;
        node_raddr = cur_q.par;
        len_d      = CNW'(new_len);
        if (cur_idx_q == '0 || 32'(new_len) == 32'(NODE_CAPACITY)) begin
          found_d    = 1'b1;
          last_len_d = (32'(new_len) > LENGTH_LIMIT) ? 10'(LENGTH_LIMIT) : 10'(new_len);
          state_d    = ST_DONE;
        end else begin
          state_d = ST_PWAIT;
        end
      end

      ST_PWAIT: begin
        cur_d     = node_rd;
        cur_idx_d = cur_q.par;
        state_d   = ST_PATH;
      end

      // hand the result to the output register
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {1'b0, sy_q, sx_q, last_len_q, found_q};
          state_d   = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      found_q    <= 1'b0;
      last_len_q <= '0;
      m_valid_q  <= 1'b0;
      cnt_q      <= '0;
    end else begin
      state_q    <= state_d;
      found_q    <= found_d;
      last_len_q <= last_len_d;
      m_valid_q  <= m_valid_d;
      cnt_q      <= cnt_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    w_q       <= w_d;
    h_q       <= h_d;
    cap_q     <= cap_d;
    tx_q      <= tx_d;
    ty_q      <= ty_d;
    cur_q     <= cur_d;
    cur_idx_q <= cur_idx_d;
    dir_q     <= dir_d;
    nx_q      <= nx_d;
    ny_q      <= ny_d;
    nest_q    <= nest_d;
    i_q       <= i_d;
    have_q    <= have_d;
    bestf_q   <= bestf_d;
    best_q    <= best_d;
    len_q     <= len_d;
    sx_q      <= sx_d;
    sy_q      <= sy_d;
    m_data_q  <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

>>> tb/gasp_checker.sv
// ----------------------------------------------------------------------------
// gasp_checker: result predictor and scoreboard for the grid path search
// Watches the config port and both streams. It keeps its own map, node table
// and path store, predicts one result beat per accepted command beat and
// compares each result beat field by field, in order.
// ----------------------------------------------------------------------------
module gasp_checker
  import gasp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [6:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,
  output int          pending_o,
  output int          errors_o,
  output int          found_cnt_o
);

  localparam int MAP_W = 64;
  localparam int MAP_H = 64;
  localparam int SLOTS = 512;

  typedef struct packed {
    logic [5:0] step_y;
    logic [5:0] step_x;
    logic [9:0] path_len;
    logic       found;
  } result_t;

  result_t     expected_q[$];

  // predictor state
  bit          cell_open[MAP_W*MAP_H];
  bit          nd_used[SLOTS];
  bit          nd_live[SLOTS];
  int          nd_x[SLOTS];
  int          nd_y[SLOTS];
  int unsigned nd_g[SLOTS];
  int unsigned nd_h[SLOTS];
  int unsigned nd_parent[SLOTS];
  logic [5:0]  trail_x[SLOTS];
  logic [5:0]  trail_y[SLOTS];
  bit          was_found;
  int unsigned trail_len;
  logic [6:0]  cols_reg;
  logic [6:0]  rows_reg;

  function automatic int unsigned absdiff(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  // visit one neighbor of the node being expanded
  function automatic void visit_neighbor(int cur, int dx, int dy, int tx, int ty,
                                         int w, int h, int cap);
    int x;
    int y;
    x = nd_x[cur] + dx;
    y = nd_y[cur] + dy;
    if (x < 0 || x >= w || y < 0 || y >= h) return;
    if (!cell_open[x + y*MAP_W]) return;
    for (int i = 0; i < cap; i++) begin
      if (nd_used[i] && nd_x[i] == x && nd_y[i] == y) begin
        // a cheaper way in only moves the parent
        if (nd_g[i] > nd_g[cur] + 1) nd_parent[i] = cur;
        return;
      end
    end
    for (int i = 0; i < cap; i++) begin
      if (!nd_used[i]) begin
        nd_used[i]   = 1'b1;
        nd_live[i]   = 1'b1;
        nd_x[i]      = x;
        nd_y[i]      = y;
        nd_h[i]      = absdiff(x, tx) + absdiff(y, ty);
        nd_g[i]      = nd_g[cur] + 1;
        nd_parent[i] = cur;
        return;
      end
    end
  endfunction

  function automatic void search_path(int fx, int fy, int tx, int ty);
    int          w;
    int          h;
    int          cap;
    int          cur;
    int          best;
    int unsigned best_f;
    int unsigned f;
    int unsigned n;
    bit          have;
    w = (cols_reg > MAP_W) ? MAP_W : int'(cols_reg);
    h = (rows_reg > MAP_H) ? MAP_H : int'(rows_reg);
    was_found = 1'b0;
    trail_len = 0;
    for (int i = 0; i < SLOTS; i++) begin
      nd_used[i] = 1'b0;
      nd_live[i] = 1'b0;
    end
    if (fx >= w || fy >= h || tx >= w || ty >= h) return;
    cap = (w*h > SLOTS) ? SLOTS : w*h;
    nd_used[0] = 1'b1;
    nd_live[0] = 1'b1;
    nd_x[0] = fx;
    nd_y[0] = fy;
    nd_g[0] = 0;
    nd_h[0] = absdiff(fx, tx) + absdiff(fy, ty);
    nd_parent[0] = 0;
    cur = 0;
    forever begin
      if (nd_x[cur] == tx && nd_y[cur] == ty) break;
      visit_neighbor(cur,  0, -1, tx, ty, w, h, cap);
      visit_neighbor(cur, -1,  0, tx, ty, w, h, cap);
      visit_neighbor(cur,  1,  0, tx, ty, w, h, cap);
      visit_neighbor(cur,  0,  1, tx, ty, w, h, cap);
      nd_live[cur] = 1'b0;
      // first lowest f among open nodes
      have = 1'b0;
      best = 0;
      best_f = 0;
      for (int i = 0; i < cap; i++) begin
        if (nd_used[i] && nd_live[i]) begin
          f = nd_g[i] + nd_h[i];
          if (!have || f < best_f) begin
            have = 1'b1;
            best_f = f;
            best = i;
          end
        end
      end
      if (!have) return;
      cur = best;
    end
    // walk back from the goal
    n = 0;
    while (n < SLOTS) begin
      trail_x[n] = nd_x[cur][5:0];
      trail_y[n] = nd_y[cur][5:0];
      n++;
      if (cur == 0) break;
      cur = nd_parent[cur] % SLOTS;
    end
    was_found = 1'b1;
    trail_len = (n > LENGTH_LIMIT) ? LENGTH_LIMIT : n;
  endfunction

  function automatic result_t predict_beat(logic [1:0] cmd, logic [47:0] d);
    result_t r;
    int unsigned k;
    r = '0;
    case (cmd)
      CMD_LOAD: begin
        cell_open[int'(d[5:0]) + int'(d[11:6])*MAP_W] = d[12];
      end
      CMD_SEARCH: begin
        search_path(int'(d[18:13]), int'(d[24:19]), int'(d[30:25]), int'(d[36:31]));
      end
      CMD_READ: begin
        k = 32'(d[45:37]);
        if (k < trail_len && k < SLOTS) begin
          r.step_x = trail_x[k];
          r.step_y = trail_y[k];
        end
      end
      default: ;
    endcase
    r.found    = was_found;
    r.path_len = trail_len[9:0];
    return r;
  endfunction

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      expected_q.delete();
      for (int i = 0; i < MAP_W*MAP_H; i++) cell_open[i] = 1'b0;
      was_found   = 1'b0;
      trail_len   = 0;
      cols_reg    = 7'd64;
      rows_reg    = 7'd64;
      errors_o    <= 0;
      found_cnt_o <= 0;
    end else begin
      // result beat against the oldest expectation
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[22:0];
        if (expected_q.size() == 0) begin
          if (errors_o < 10)
            $display("%0t: result beat with nothing expected: %h", $realtime, got);
          errors_o <= errors_o + 1;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            if (errors_o < 10)
              $display("%0t: mismatch found %b/%b len %0d/%0d step %0d,%0d / %0d,%0d",
                       $realtime, want.found, got.found, want.path_len, got.path_len,
                       want.step_x, want.step_y, got.step_x, got.step_y);
            errors_o <= errors_o + 1;
          end
        end
      end
      // register writes
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_WIDTH) cols_reg = cfg_data_i;
        else                        rows_reg = cfg_data_i;
      end
      // command beat
      if (s_axis_tvalid && s_axis_tready) begin
        want = predict_beat(s_axis_tuser, s_axis_tdata);
        expected_q.push_back(want);
        if (s_axis_tuser == CMD_SEARCH && want.found) found_cnt_o <= found_cnt_o + 1;
      end
    end
  end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for grid_astar_path_search
// Directed map and search cases, then random phases over many grid sizes,
// with random gaps on the command side and stalls on the result side.
// ----------------------------------------------------------------------------
module tb_top;
  import gasp_pkg::*;

  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int ITEM_GOAL   = 1900;
  localparam int QUIET_LIMIT = 600000;
  localparam int DRAIN_WAIT  = 20;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [6:0]  cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  int pending;
  int errors;
  int found_cnt;
  int items;
  int searches;
  int quiet = 0;
  bit gaps_on;
  int stall_left = 0;
  int cols;
  int rows;

  always #5 clk_i = ~clk_i;

  grid_astar_path_search u_top (.*);

  gasp_checker u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .pending_o(pending), .errors_o(errors), .found_cnt_o(found_cnt)
  );

  // result side back pressure in short bursts
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 3);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet == QUIET_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // one command beat; valid stays high into the next beat unless a gap comes
  task automatic send_cmd(logic [1:0] cmd, logic [47:0] d);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= d;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    items++;
    if (cmd == CMD_SEARCH) searches++;
  endtask

  function automatic logic [47:0] noise();
    return 48'({$urandom, $urandom});
  endfunction

  task automatic load_cell(int x, int y, bit pass);
    logic [47:0] d;
    d = noise();
    d[5:0] = 6'(x);
    d[11:6] = 6'(y);
    d[12] = pass;
    send_cmd(CMD_LOAD, d);
  endtask

  task automatic search(int fx, int fy, int tx, int ty);
    logic [47:0] d;
    d = noise();
    d[18:13] = 6'(fx);
    d[24:19] = 6'(fy);
    d[30:25] = 6'(tx);
    d[36:31] = 6'(ty);
    send_cmd(CMD_SEARCH, d);
  endtask

  task automatic read_step(int k);
    logic [47:0] d;
    d = noise();
    d[45:37] = 9'(k);
    send_cmd(CMD_READ, d);
  endtask

  // registers change only with the block idle
  task automatic set_grid(int w, int h);
    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_WAIT) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_WIDTH;
    cfg_data_i <= 7'(w);
    @(negedge clk_i);
    cfg_idx_i  <= REG_HEIGHT;
    cfg_data_i <= 7'(h);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    cols = (w > 64) ? 64 : w;
    rows = (h > 64) ? 64 : h;
  endtask

  // every cell of the grid in use gets a known value before any search
  task automatic fill_grid();
    for (int y = 0; y < rows; y++)
      for (int x = 0; x < cols; x++)
        load_cell(x, y, $urandom_range(0, 9) < 7);
  endtask

  task automatic random_phase(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      gaps_on = (items < ITEM_GOAL - 300);
      r = $urandom_range(0, 99);
      if (r < 30) begin
        if (cols > 0 && rows > 0 && $urandom_range(0, 9) != 0)
          load_cell($urandom_range(0, cols-1), $urandom_range(0, rows-1),
                    $urandom_range(0, 9) < 7);
        else
          load_cell($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 1));
      end else if (r < 60) begin
        if (cols > 0 && rows > 0 && $urandom_range(0, 6) != 0)
          search($urandom_range(0, cols-1), $urandom_range(0, rows-1),
                 $urandom_range(0, cols-1), $urandom_range(0, rows-1));
        else
          search($urandom_range(0, 63), $urandom_range(0, 63),
                 $urandom_range(0, 63), $urandom_range(0, 63));
      end else if (r < 95) begin
        if ($urandom_range(0, 9) != 0) read_step($urandom_range(0, cols + rows + 2));
        else read_step($urandom_range(0, 511));
      end else begin
        send_cmd(CMD_SPARE, noise());
      end
    end
  endtask

  initial begin
    items = 0;
    searches = 0;
    gaps_on = 1'b1;
    cols = 64;
    rows = 64;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: 3x2 map with a wall at (1,0)
    set_grid(3, 2);
    for (int y = 0; y < 2; y++)
      for (int x = 0; x < 3; x++)
        load_cell(x, y, !(x == 1 && y == 0));
    load_cell(63, 63, 1'b1);             // far corner, outside the grid in use
    search(0, 0, 0, 0);                  // start on goal
    read_step(0);
    search(0, 0, 2, 0);                  // detour around the wall
    read_step(0);
    read_step(3);
    read_step(4);
    read_step(511);                      // index past the path
    search(5, 0, 0, 0);                  // start off the grid
    search(0, 0, 63, 63);                // goal off the grid
    search(0, 0, 1, 0);                  // goal blocked
    send_cmd(CMD_SPARE, '1);
    read_step(0);
    set_grid(0, 2);                      // empty grid
    search(0, 0, 0, 0);

    // random phases, extremes first, then mostly small grids
    set_grid(127, 1); fill_grid(); random_phase(15);
    set_grid(64, 2);  fill_grid(); random_phase(12);
    set_grid(2, 64);  fill_grid(); random_phase(12);
    set_grid(1, 100); fill_grid(); random_phase(12);
    set_grid(5, 0);   random_phase(10);
    set_grid(1, 1);   fill_grid(); random_phase(10);
    while (items < ITEM_GOAL) begin
      set_grid($urandom_range(1, 7), $urandom_range(1, 7));
      fill_grid();
      random_phase($urandom_range(20, 60));
    end
    s_axis_tvalid <= 1'b0;
    gaps_on = 1'b0;

    wait (pending == 0);
    repeat (DRAIN_WAIT) @(negedge clk_i);
    $display("tb_top: %0d command beats, %0d searches, %0d reached the goal",
             items, searches, found_cnt);
    if (errors == 0 && pending == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
